// ===== hdl/priority_spool_drop_queue_defines.svh =====
// Assertion macros for the priority spool drop queue
`ifndef PRIORITY_SPOOL_DROP_QUEUE_DEFINES_SVH
`define PRIORITY_SPOOL_DROP_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define PSDQ_ASSERT_HOLDS(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define PSDQ_ASSERT_IMPLIES(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define PSDQ_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PSDQ_ASSERT_HOLDS(name, prop, msg)
`define PSDQ_ASSERT_IMPLIES(name, ante, cons, msg)
`define PSDQ_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ===== hdl/psdq_pkg.sv =====
package psdq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int SPOOL_DEPTH = 16;
   localparam int TAG_BITS = 32;

   localparam int PAYLOAD_BITS = 32;
   localparam int STORE_TAG_BITS = (TAG_BITS < PAYLOAD_BITS) ? TAG_BITS : PAYLOAD_BITS;
   localparam int PRIO_BITS = 2;
   localparam int REQ_BITS = 2;
   localparam int STATUS_BITS = 4;
   localparam int LIMIT_BITS = 7;
   localparam int QCOUNT_OUT_BITS = 7;
   localparam int SCOUNT_OUT_BITS = 5;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 7;

   localparam int QIDX_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int SIDX_BITS = (SPOOL_DEPTH > 1) ? $clog2(SPOOL_DEPTH) : 1;
   localparam int SCNT_BITS = $clog2(SPOOL_DEPTH + 1);
   localparam int SSUM_BITS = SCNT_BITS + 1;
   localparam int CAP_BITS = (QCNT_BITS > LIMIT_BITS) ? QCNT_BITS : LIMIT_BITS;

   typedef logic [QCNT_BITS-1:0] qcnt_type;
   typedef logic [SIDX_BITS-1:0] sidx_type;
   typedef logic [SCNT_BITS-1:0] scnt_type;
   typedef logic [SSUM_BITS-1:0] ssum_type;
   typedef logic [CAP_BITS-1:0] cap_type;
   typedef logic [STORE_TAG_BITS-1:0] tag_type;

   typedef enum logic [REQ_BITS-1:0] {
      REQ_ENQUEUE   = 2'd0,
      REQ_DEQUEUE   = 2'd1,
      REQ_FLUSH     = 2'd2,
      REQ_FLUSH_ALT = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_QUEUED       = 4'd0,
      ST_SPOOLED      = 4'd1,
      ST_QUEUED_DROP  = 4'd2,
      ST_SPOOL_FULL   = 4'd3,
      ST_NO_DROPPABLE = 4'd4,
      ST_DISABLED     = 4'd5,
      ST_DELIVERED    = 4'd6,
      ST_EMPTY        = 4'd7,
      ST_FLUSHED      = 4'd8
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ENABLE      = 2'd0,
      CSR_QUEUE_LIMIT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [PRIO_BITS-1:0] prio;
      tag_type              tag;
   } entry_type;

   typedef struct packed {
      logic append;
      logic drop_append;
      logic pop;
      logic clear;
   } queue_cmd_type;

   typedef struct packed {
      qcnt_type  fill;
      qcnt_type  fill_next;
      entry_type head;
      logic      drop_any;
   } queue_stat_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } spool_cmd_type;

   typedef struct packed {
      scnt_type fill;
      scnt_type fill_next;
      tag_type  head;
      logic     full;
   } spool_stat_type;

   typedef struct packed {
      status_type                   status;
      logic                         out_valid;
      logic [PRIO_BITS-1:0]         out_priority;
      logic [PAYLOAD_BITS-1:0]      out_payload;
      logic [QCOUNT_OUT_BITS-1:0]   queue_count;
      logic [SCOUNT_OUT_BITS-1:0]   spool_count;
   } rsp_word_type;

endpackage

// ===== hdl/psdq_req_if.sv =====
interface psdq_req_if;
   logic                                valid;
   logic                                ready;
   logic [psdq_pkg::REQ_BITS-1:0]       req_type;
   logic [psdq_pkg::PRIO_BITS-1:0]      priority_req;
   logic [psdq_pkg::PAYLOAD_BITS-1:0]   payload;

   modport source (output valid, req_type, priority_req, payload, input ready);
   modport sink (input valid, req_type, priority_req, payload, output ready);
endinterface

// ===== hdl/psdq_rsp_if.sv =====
interface psdq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [psdq_pkg::STATUS_BITS-1:0]     status;
   logic                                 out_valid;
   logic [psdq_pkg::PRIO_BITS-1:0]       out_priority;
   logic [psdq_pkg::PAYLOAD_BITS-1:0]    out_payload;
   logic [psdq_pkg::QCOUNT_OUT_BITS-1:0] queue_count;
   logic [psdq_pkg::SCOUNT_OUT_BITS-1:0] spool_count;

   modport source (output valid, status, out_valid, out_priority, out_payload,
                   queue_count, spool_count, input ready);
   modport sink (input valid, status, out_valid, out_priority, out_payload,
                 queue_count, spool_count, output ready);
endinterface

// ===== hdl/psdq_csr_if.sv =====
interface psdq_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [psdq_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [psdq_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/psdq_cell.sv =====
module psdq_cell (
   input  logic                 clock,
   input  logic                 shift,
   input  logic                 load,
   input  psdq_pkg::entry_type  next_entry,
   input  psdq_pkg::entry_type  new_entry,
   output psdq_pkg::entry_type  entry
);

   psdq_pkg::entry_type entry_ff;
   psdq_pkg::entry_type entry_in;

   always_comb begin
      if (load) begin
         entry_in = new_entry;
      end else if (shift) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== hdl/psdq_cell_row.sv =====
module psdq_cell_row (
   input  logic                       clock,
   input  logic                       reset,
   input  psdq_pkg::queue_cmd_type    cmd,
   input  psdq_pkg::entry_type        new_entry,
   output psdq_pkg::queue_stat_type   stat
);

   psdq_pkg::qcnt_type  fill_ff;
   psdq_pkg::qcnt_type  fill_in;
   psdq_pkg::qcnt_type  last_pos;
   psdq_pkg::entry_type slot_entry [psdq_pkg::QUEUE_DEPTH];
   logic [psdq_pkg::QUEUE_DEPTH-1:0] occupied;
   logic [psdq_pkg::QUEUE_DEPTH-1:0] droppable;
   logic [psdq_pkg::QUEUE_DEPTH-1:0] shift;
   logic [psdq_pkg::QUEUE_DEPTH-1:0] load;
   logic [psdq_pkg::QUEUE_DEPTH-1:0] prefix [psdq_pkg::QIDX_BITS+1];

   // occupancy and oldest-non-P0 search (log-depth prefix OR)
   always_comb begin
      for (int i = 0; i < psdq_pkg::QUEUE_DEPTH; i++) begin
         occupied[i]  = psdq_pkg::qcnt_type'(i) < fill_ff;
         droppable[i] = occupied[i] && (slot_entry[i].prio != '0);
      end
      prefix[0] = droppable;
      for (int s = 0; s < psdq_pkg::QIDX_BITS; s++) begin
         prefix[s+1] = prefix[s] | (prefix[s] << (1 << s));
      end
   end

   assign last_pos = fill_ff - psdq_pkg::qcnt_type'(1);

   always_comb begin
      for (int i = 0; i < psdq_pkg::QUEUE_DEPTH; i++) begin
         load[i]  = (cmd.append && (psdq_pkg::qcnt_type'(i) == fill_ff))
                 || (cmd.drop_append && (psdq_pkg::qcnt_type'(i) == last_pos));
         shift[i] = cmd.pop || (cmd.drop_append && prefix[psdq_pkg::QIDX_BITS][i]);
      end
   end

   always_comb begin
      if (cmd.clear) begin
         fill_in = '0;
      end else if (cmd.append) begin
         fill_in = fill_ff + psdq_pkg::qcnt_type'(1);
      end else if (cmd.pop) begin
         fill_in = fill_ff - psdq_pkg::qcnt_type'(1);
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   for (genvar g = 0; g < psdq_pkg::QUEUE_DEPTH; g++) begin : g_slot
      psdq_pkg::entry_type neighbour;
      if (g == psdq_pkg::QUEUE_DEPTH - 1) begin : g_tail
         assign neighbour = slot_entry[g];
      end else begin : g_body
         assign neighbour = slot_entry[g+1];
      end
      psdq_cell u_cell (
         .clock      (clock),
         .shift      (shift[g]),
         .load       (load[g]),
         .next_entry (neighbour),
         .new_entry  (new_entry),
         .entry      (slot_entry[g])
      );
   end

   assign stat.fill      = fill_ff;
   assign stat.fill_next = fill_in;
   assign stat.head      = slot_entry[0];
   assign stat.drop_any  = prefix[psdq_pkg::QIDX_BITS][psdq_pkg::QUEUE_DEPTH-1];

endmodule

// ===== hdl/psdq_spool.sv =====
module psdq_spool (
   input  logic                      clock,
   input  logic                      reset,
   input  psdq_pkg::spool_cmd_type   cmd,
   input  psdq_pkg::tag_type         push_tag,
   output psdq_pkg::spool_stat_type  stat
);

   psdq_pkg::sidx_type head_ff;
   psdq_pkg::sidx_type head_in;
   psdq_pkg::scnt_type fill_ff;
   psdq_pkg::scnt_type fill_in;
   psdq_pkg::ssum_type tail_sum;
   psdq_pkg::ssum_type tail_wrap;
   psdq_pkg::tag_type  spool_mem [psdq_pkg::SPOOL_DEPTH];

   assign tail_sum  = psdq_pkg::ssum_type'(head_ff) + psdq_pkg::ssum_type'(fill_ff);
   assign tail_wrap = (tail_sum >= psdq_pkg::ssum_type'(psdq_pkg::SPOOL_DEPTH))
                    ? tail_sum - psdq_pkg::ssum_type'(psdq_pkg::SPOOL_DEPTH) : tail_sum;

   always_comb begin
      if (cmd.clear) begin
         head_in = '0;
         fill_in = '0;
      end else if (cmd.push) begin
         head_in = head_ff;
         fill_in = fill_ff + psdq_pkg::scnt_type'(1);
      end else if (cmd.pop) begin
         head_in = (head_ff == psdq_pkg::sidx_type'(psdq_pkg::SPOOL_DEPTH - 1))
                 ? '0 : head_ff + psdq_pkg::sidx_type'(1);
         fill_in = fill_ff - psdq_pkg::scnt_type'(1);
      end else begin
         head_in = head_ff;
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         spool_mem[tail_wrap[psdq_pkg::SIDX_BITS-1:0]] <= push_tag;
      end
   end

   assign stat.fill      = fill_ff;
   assign stat.fill_next = fill_in;
   assign stat.head      = spool_mem[head_ff];
   assign stat.full      = fill_ff >= psdq_pkg::scnt_type'(psdq_pkg::SPOOL_DEPTH);

endmodule

// ===== hdl/priority_spool_drop_queue.sv =====
// Priority spool drop queue.
// req_bus carries one request word: enqueue (priority, tag), dequeue, or flush.
// rsp_bus returns exactly one word per request: status, the delivered item
// when a dequeue finds one, and the queue and spool fill after the request.
// csr_bus writes enable (index 0) and queue_limit (index 1); other indexes
// are ignored. Dropping enable from 1 to 0 empties both stores.
// Each accepted request updates the cell row and spool in the cycle it is
// taken; its response is registered and presented once earlier ones are
// taken. One request per cycle is sustained while the output buffer has
// room, set by the shift and combinational oldest-non-P0 search over the cell row.
// Responses pass through a two-word output buffer, so a request is still
// taken while one response waits; req_bus.ready drops only with both held.
// Reset empties the queue and spool, clears the buffer, disables the block
// and sets queue_limit to zero (full built depth).
`include "priority_spool_drop_queue_defines.svh"

module priority_spool_drop_queue (
   input logic          clock,
   input logic          reset,
   psdq_req_if.sink     req_bus,
   psdq_rsp_if.source   rsp_bus,
   psdq_csr_if.sink     csr_bus
);

   logic                                   enable_ff;
   logic                                   enable_in;
   logic [psdq_pkg::LIMIT_BITS-1:0]        limit_ff;
   logic [psdq_pkg::LIMIT_BITS-1:0]        limit_in;
   logic                                   csr_fire;
   logic                                   cfg_clear;

   logic                                   req_fire;
   logic                                   flush_req;
   psdq_pkg::req_code_type                 req_code;
   psdq_pkg::cap_type                      capacity;
   logic                                   queue_full;
   psdq_pkg::entry_type                    new_entry;
   psdq_pkg::queue_cmd_type                qcmd;
   psdq_pkg::queue_stat_type               qstat;
   psdq_pkg::spool_cmd_type                scmd;
   psdq_pkg::spool_stat_type               sstat;
   psdq_pkg::rsp_word_type                 result;

   psdq_pkg::rsp_word_type                 slot0_ff;
   psdq_pkg::rsp_word_type                 slot0_in;
   psdq_pkg::rsp_word_type                 slot1_ff;
   psdq_pkg::rsp_word_type                 slot1_in;
   logic [1:0]                             count_ff;
   logic [1:0]                             count_in;
   logic [1:0]                             write_pos;
   logic                                   rsp_fire;

   // configuration
   assign csr_bus.ready = 1'b1;
   assign csr_fire = csr_bus.valid && csr_bus.ready;

   always_comb begin
      enable_in = enable_ff;
      limit_in  = limit_ff;
      cfg_clear = 1'b0;
      if (csr_fire) begin
         unique case (psdq_pkg::csr_index_type'(csr_bus.index))
            psdq_pkg::CSR_ENABLE: begin
               enable_in = csr_bus.data[0];
               cfg_clear = enable_ff && !csr_bus.data[0];
            end
            psdq_pkg::CSR_QUEUE_LIMIT: begin
               limit_in = csr_bus.data[psdq_pkg::LIMIT_BITS-1:0];
            end
            default: begin
               enable_in = enable_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         limit_ff  <= '0;
      end else begin
         enable_ff <= enable_in;
         limit_ff  <= limit_in;
      end
   end

   // request decode
   assign req_fire = req_bus.valid && req_bus.ready;
   assign req_code = psdq_pkg::req_code_type'(req_bus.req_type);

   always_comb begin
      unique case (req_code) inside
         psdq_pkg::REQ_FLUSH, psdq_pkg::REQ_FLUSH_ALT: flush_req = 1'b1;
         default:                                      flush_req = 1'b0;
      endcase
   end

   assign capacity = ((limit_ff == '0)
                   || (psdq_pkg::cap_type'(limit_ff) > psdq_pkg::cap_type'(psdq_pkg::QUEUE_DEPTH)))
                   ? psdq_pkg::cap_type'(psdq_pkg::QUEUE_DEPTH) : psdq_pkg::cap_type'(limit_ff);
   assign queue_full = psdq_pkg::cap_type'(qstat.fill) >= capacity;

   assign new_entry.prio = req_bus.priority_req;
   assign new_entry.tag  = req_bus.payload[psdq_pkg::STORE_TAG_BITS-1:0];

   always_comb begin
      qcmd = '0;
      scmd = '0;
      result.out_valid    = 1'b0;
      result.out_priority = '0;
      result.out_payload  = '0;
      result.status       = psdq_pkg::ST_EMPTY;
      if (flush_req) begin
         result.status = psdq_pkg::ST_FLUSHED;
         qcmd.clear    = req_fire;
         scmd.clear    = req_fire;
      end else if (!enable_ff) begin
         result.status = psdq_pkg::ST_DISABLED;
      end else if (req_code == psdq_pkg::REQ_ENQUEUE) begin
         if (!queue_full) begin
            result.status = psdq_pkg::ST_QUEUED;
            qcmd.append   = req_fire;
         end else if (req_bus.priority_req == '0) begin
            if (sstat.full) begin
               result.status = psdq_pkg::ST_SPOOL_FULL;
            end else begin
               result.status = psdq_pkg::ST_SPOOLED;
               scmd.push     = req_fire;
            end
         end else if (qstat.drop_any) begin
            result.status    = psdq_pkg::ST_QUEUED_DROP;
            qcmd.drop_append = req_fire;
         end else begin
            result.status = psdq_pkg::ST_NO_DROPPABLE;
         end
      end else if (sstat.fill != '0) begin
         result.status      = psdq_pkg::ST_DELIVERED;
         result.out_valid   = 1'b1;
         result.out_payload = psdq_pkg::PAYLOAD_BITS'(sstat.head);
         scmd.pop           = req_fire;
      end else if (qstat.fill != '0) begin
         result.status       = psdq_pkg::ST_DELIVERED;
         result.out_valid    = 1'b1;
         result.out_priority = qstat.head.prio;
         result.out_payload  = psdq_pkg::PAYLOAD_BITS'(qstat.head.tag);
         qcmd.pop            = req_fire;
      end
      qcmd.clear = qcmd.clear || cfg_clear;
      scmd.clear = scmd.clear || cfg_clear;
      result.queue_count = psdq_pkg::QCOUNT_OUT_BITS'(qstat.fill_next);
      result.spool_count = psdq_pkg::SCOUNT_OUT_BITS'(sstat.fill_next);
   end

   psdq_cell_row u_row (
      .clock     (clock),
      .reset     (reset),
      .cmd       (qcmd),
      .new_entry (new_entry),
      .stat      (qstat)
   );

   psdq_spool u_spool (
      .clock    (clock),
      .reset    (reset),
      .cmd      (scmd),
      .push_tag (new_entry.tag),
      .stat     (sstat)
   );

   // two-word response buffer
   assign rsp_fire  = rsp_bus.valid && rsp_bus.ready;
   assign write_pos = count_ff - {1'b0, rsp_fire};

   always_comb begin
      slot0_in = rsp_fire ? slot1_ff : slot0_ff;
      slot1_in = slot1_ff;
      if (req_fire) begin
         if (write_pos == 2'd0) begin
            slot0_in = result;
         end else begin
            slot1_in = result;
         end
      end
      count_in = count_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign req_bus.ready        = count_ff != 2'd2;
   assign rsp_bus.valid        = count_ff != 2'd0;
   assign rsp_bus.status       = slot0_ff.status;
   assign rsp_bus.out_valid    = slot0_ff.out_valid;
   assign rsp_bus.out_priority = slot0_ff.out_priority;
   assign rsp_bus.out_payload  = slot0_ff.out_payload;
   assign rsp_bus.queue_count  = slot0_ff.queue_count;
   assign rsp_bus.spool_count  = slot0_ff.spool_count;

   `PSDQ_ASSERT_HOLDS(a_queue_bound, qstat.fill <= psdq_pkg::qcnt_type'(psdq_pkg::QUEUE_DEPTH), "queue fill beyond depth")
   `PSDQ_ASSERT_HOLDS(a_spool_bound, sstat.fill <= psdq_pkg::scnt_type'(psdq_pkg::SPOOL_DEPTH), "spool fill beyond depth")
   `PSDQ_ASSERT_NEXT(a_flush_empties, req_fire && flush_req, (qstat.fill == '0) && (sstat.fill == '0), "flush left entries")
   `PSDQ_ASSERT_IMPLIES(a_delivery_status, rsp_bus.valid && rsp_bus.out_valid, rsp_bus.status == psdq_pkg::ST_DELIVERED, "delivered word without delivered status")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_LEN = 300;
   localparam logic [psdq_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [psdq_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      psdq_pkg::req_code_type            kind;
      logic [psdq_pkg::PRIO_BITS-1:0]    prio;
      logic [psdq_pkg::PAYLOAD_BITS-1:0] payload;
   } req_word_type;

   logic clock = 1'b0;
   logic reset;

   psdq_req_if req_bus ();
   psdq_rsp_if rsp_bus ();
   psdq_csr_if csr_bus ();

   priority_spool_drop_queue dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #10 clock = ~clock;

   req_word_type           request_backlog[$];
   psdq_pkg::rsp_word_type awaited_responses[$];

   // shadow of the block
   psdq_pkg::entry_type                queue_shadow[$];
   psdq_pkg::tag_type                  spool_shadow[$];
   logic                               shadow_enable;
   logic [psdq_pkg::LIMIT_BITS-1:0]    shadow_limit;

   bit quiet;
   bit pressure_req;
   bit hold_off;
   int hold_cnt;
   int gap_left;
   int stall_left;
   bit req_hold;
   int errors;
   int requests_sent;
   int responses_checked;
   int cycle_count;
   int status_seen [0:15];
   req_word_type taken;
   psdq_pkg::rsp_word_type got;
   psdq_pkg::rsp_word_type want;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic psdq_pkg::rsp_word_type next_response(req_word_type w);
      psdq_pkg::rsp_word_type r;
      psdq_pkg::entry_type    e;
      int                     cap;
      int                     pos;
      r = '0;
      e.prio = w.prio;
      e.tag  = psdq_pkg::tag_type'(w.payload);
      if (w.kind == psdq_pkg::REQ_FLUSH || w.kind == psdq_pkg::REQ_FLUSH_ALT) begin
         queue_shadow.delete();
         spool_shadow.delete();
         r.status = psdq_pkg::ST_FLUSHED;
      end else if (!shadow_enable) begin
         r.status = psdq_pkg::ST_DISABLED;
      end else if (w.kind == psdq_pkg::REQ_ENQUEUE) begin
         cap = (shadow_limit == 0 || shadow_limit > psdq_pkg::QUEUE_DEPTH)
             ? psdq_pkg::QUEUE_DEPTH : int'(shadow_limit);
         if (queue_shadow.size() < cap) begin
            queue_shadow.insert(queue_shadow.size(), e);
            r.status = psdq_pkg::ST_QUEUED;
         end else if (w.prio == 0) begin
            if (spool_shadow.size() >= psdq_pkg::SPOOL_DEPTH) begin
               r.status = psdq_pkg::ST_SPOOL_FULL;
            end else begin
               spool_shadow.insert(spool_shadow.size(), e.tag);
               r.status = psdq_pkg::ST_SPOOLED;
            end
         end else begin
            pos = -1;
            for (int i = 0; i < queue_shadow.size(); i++) begin
               if (pos < 0 && queue_shadow[i].prio != 0) pos = i;
            end
            if (pos < 0) begin
               r.status = psdq_pkg::ST_NO_DROPPABLE;
            end else begin
               queue_shadow.delete(pos);
               queue_shadow.insert(queue_shadow.size(), e);
               r.status = psdq_pkg::ST_QUEUED_DROP;
            end
         end
      end else if (spool_shadow.size() != 0) begin
         r.out_valid = 1'b1;
         r.out_payload = spool_shadow[0];
         spool_shadow.delete(0);
         r.status = psdq_pkg::ST_DELIVERED;
      end else if (queue_shadow.size() != 0) begin
         e = queue_shadow[0];
         queue_shadow.delete(0);
         r.out_valid = 1'b1;
         r.out_priority = e.prio;
         r.out_payload = e.tag;
         r.status = psdq_pkg::ST_DELIVERED;
      end else begin
         r.status = psdq_pkg::ST_EMPTY;
      end
      r.queue_count = psdq_pkg::QCOUNT_OUT_BITS'(queue_shadow.size());
      r.spool_count = psdq_pkg::SCOUNT_OUT_BITS'(spool_shadow.size());
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left <= 0;
      end else begin
         req_hold = req_bus.valid && !req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            taken = request_backlog[0];
            request_backlog.delete(0);
            awaited_responses.insert(awaited_responses.size(), next_response(taken));
            requests_sent++;
         end
         if (!req_hold) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_bus.valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               req_bus.valid <= 1'b1;
               req_bus.req_type <= request_backlog[0].kind;
               req_bus.priority_req <= request_backlog[0].prio;
               req_bus.payload <= request_backlog[0].payload;
               gap_left <= quiet ? 0 : pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_off <= 1'b0;
         hold_cnt <= 0;
      end else if (pressure_req && hold_cnt < HOLD_LEN) begin
         hold_off <= 1'b1;
         hold_cnt <= hold_cnt + 1;
      end else begin
         hold_off <= 1'b0;
         if (!pressure_req) hold_cnt <= 0;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{status: psdq_pkg::status_type'(rsp_bus.status),
                    out_valid: rsp_bus.out_valid,
                    out_priority: rsp_bus.out_priority, out_payload: rsp_bus.out_payload,
                    queue_count: rsp_bus.queue_count, spool_count: rsp_bus.spool_count};
            responses_checked++;
            if (awaited_responses.size() == 0) begin
               errors++;
               $display("%0t: unexpected word: expected none, got st=%0d ov=%0b pr=%0d pay=%h qc=%0d sc=%0d",
                        $time, got.status, got.out_valid, got.out_priority,
                        got.out_payload, got.queue_count, got.spool_count);
            end else begin
               want = awaited_responses[0];
               awaited_responses.delete(0);
               if (got !== want) begin
                  errors++;
                  $display("%0t: mismatch: expected st=%0d ov=%0b pr=%0d pay=%h qc=%0d sc=%0d",
                           $time, want.status, want.out_valid, want.out_priority,
                           want.out_payload, want.queue_count, want.spool_count);
                  $display("%0t:           got st=%0d ov=%0b pr=%0d pay=%h qc=%0d sc=%0d",
                           $time, got.status, got.out_valid, got.out_priority,
                           got.out_payload, got.queue_count, got.spool_count);
               end
               status_seen[want.status]++;
            end
         end
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout, %0d words still awaited", $time, awaited_responses.size());
         $display("simulation failed");
         $finish;
      end
   end

   function automatic void add_item(psdq_pkg::req_code_type k,
                                    logic [psdq_pkg::PRIO_BITS-1:0] p,
                                    logic [psdq_pkg::PAYLOAD_BITS-1:0] d);
      req_word_type w;
      w.kind = k;
      w.prio = p;
      w.payload = d;
      request_backlog.insert(request_backlog.size(), w);
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (request_backlog.size() != 0 || awaited_responses.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_write(logic [psdq_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [psdq_pkg::CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock);
      while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      if (idx == psdq_pkg::CSR_ENABLE) begin
         if (shadow_enable && !value[0]) begin
            queue_shadow.delete();
            spool_shadow.delete();
         end
         shadow_enable = value[0];
      end else if (idx == psdq_pkg::CSR_QUEUE_LIMIT) begin
         shadow_limit = value;
      end
      @(negedge clock);
   endtask

   task automatic set_enable(logic on);
      csr_write(psdq_pkg::CSR_ENABLE,
                {(psdq_pkg::CSR_DATA_BITS-1)'($urandom_range(0, 63)), on});
   endtask

   task automatic random_items(int n, int enq_pct, int p0_pct);
      int r;
      psdq_pkg::req_code_type k;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < enq_pct) k = psdq_pkg::REQ_ENQUEUE;
         else if (r < 97) k = psdq_pkg::REQ_DEQUEUE;
         else if (r < 99) k = psdq_pkg::REQ_FLUSH;
         else k = psdq_pkg::REQ_FLUSH_ALT;
         add_item(k, ($urandom_range(0, 99) < p0_pct) ? 2'd0
                     : psdq_pkg::PRIO_BITS'($urandom_range(1, 3)),
                  $urandom());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.req_type = psdq_pkg::REQ_ENQUEUE;
      req_bus.priority_req = '0;
      req_bus.payload = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = psdq_pkg::CSR_ENABLE;
      csr_bus.data = '0;
      shadow_enable = 1'b0;
      shadow_limit = '0;
      quiet = 1'b0;
      pressure_req = 1'b0;
      errors = 0;
      cycle_count = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // disabled after reset
      add_item(psdq_pkg::REQ_ENQUEUE, 2'd1, 32'hFFFF_FFFF);
      add_item(psdq_pkg::REQ_DEQUEUE, 2'd3, 32'h0);
      add_item(psdq_pkg::REQ_FLUSH_ALT, 2'd0, 32'h1234_5678);
      wait_idle();

      csr_write(psdq_pkg::CSR_QUEUE_LIMIT, 7'd0);
      set_enable(1'b1);
      add_item(psdq_pkg::REQ_ENQUEUE, 2'd0, 32'h0);
      add_item(psdq_pkg::REQ_ENQUEUE, 2'd3, 32'hFFFF_FFFF);
      add_item(psdq_pkg::REQ_DEQUEUE, 2'd0, 32'h0);
      add_item(psdq_pkg::REQ_DEQUEUE, 2'd0, 32'h0);
      add_item(psdq_pkg::REQ_DEQUEUE, 2'd0, 32'h0);
      add_item(psdq_pkg::REQ_ENQUEUE, 2'd2, 32'hA5A5_5A5A);
      add_item(psdq_pkg::REQ_FLUSH, 2'd0, 32'h0);
      add_item(psdq_pkg::REQ_DEQUEUE, 2'd0, 32'h0);
      wait_idle();

      // single-entry queue: spool, no-droppable, drop of the sole entry
      csr_write(psdq_pkg::CSR_QUEUE_LIMIT, 7'd1);
      add_item(psdq_pkg::REQ_ENQUEUE, 2'd0, 32'h0000_0011);
      add_item(psdq_pkg::REQ_ENQUEUE, 2'd0, 32'h0000_0022);
      add_item(psdq_pkg::REQ_ENQUEUE, 2'd1, 32'h0000_0033);
      add_item(psdq_pkg::REQ_DEQUEUE, 2'd0, 32'h0);
      add_item(psdq_pkg::REQ_DEQUEUE, 2'd0, 32'h0);
      add_item(psdq_pkg::REQ_ENQUEUE, 2'd2, 32'h0000_0044);
      add_item(psdq_pkg::REQ_ENQUEUE, 2'd3, 32'h0000_0055);
      add_item(psdq_pkg::REQ_ENQUEUE, 2'd1, 32'h0000_0066);
      wait_idle();

      // limit saturates above depth
      csr_write(psdq_pkg::CSR_QUEUE_LIMIT, 7'h7F);
      add_item(psdq_pkg::REQ_ENQUEUE, 2'd0, 32'h0000_0077);
      add_item(psdq_pkg::REQ_ENQUEUE, 2'd2, 32'h0000_0088);
      wait_idle();

      // limit below fill
      csr_write(psdq_pkg::CSR_QUEUE_LIMIT, 7'd2);
      add_item(psdq_pkg::REQ_ENQUEUE, 2'd1, 32'h0000_0099);
      wait_idle();

      // disabling empties both stores, spare indexes ignored
      set_enable(1'b0);
      csr_write(CSR_SPARE_LO, 7'h55);
      csr_write(CSR_SPARE_HI, 7'h2A);
      set_enable(1'b1);
      add_item(psdq_pkg::REQ_DEQUEUE, 2'd0, 32'h0);
      wait_idle();

      csr_write(psdq_pkg::CSR_QUEUE_LIMIT, 7'd0);
      random_items(80, 75, 25);
      wait_idle();

      csr_write(psdq_pkg::CSR_QUEUE_LIMIT, 7'd1);
      random_items(70, 65, 60);
      wait_idle();

      csr_write(psdq_pkg::CSR_QUEUE_LIMIT, 7'd3);
      random_items(70, 60, 30);
      wait_idle();

      csr_write(psdq_pkg::CSR_QUEUE_LIMIT, 7'd64);
      quiet <= 1'b1;
      random_items(70, 80, 20);
      wait_idle();
      quiet <= 1'b0;

      csr_write(psdq_pkg::CSR_QUEUE_LIMIT, 7'd100);
      random_items(50, 55, 50);
      wait_idle();

      // back-pressure: receiver holds off while the sender keeps offering
      csr_write(psdq_pkg::CSR_QUEUE_LIMIT, 7'd4);
      quiet <= 1'b1;
      pressure_req <= 1'b1;
      random_items(40, 65, 40);
      wait_idle();
      pressure_req <= 1'b0;
      quiet <= 1'b0;

      set_enable(1'b0);
      random_items(20, 50, 50);
      wait_idle();

      set_enable(1'b1);
      csr_write(psdq_pkg::CSR_QUEUE_LIMIT, 7'd2);
      random_items(60, 55, 40);
      wait_idle();

      repeat (20) @(negedge clock);
      $display("%0d requests, %0d words checked; spooled %0d, spool full %0d, dropped %0d,",
               requests_sent, responses_checked, status_seen[psdq_pkg::ST_SPOOLED],
               status_seen[psdq_pkg::ST_SPOOL_FULL], status_seen[psdq_pkg::ST_QUEUED_DROP]);
      $display("no droppable %0d, disabled %0d, delivered %0d, empty %0d, flushed %0d",
               status_seen[psdq_pkg::ST_NO_DROPPABLE], status_seen[psdq_pkg::ST_DISABLED],
               status_seen[psdq_pkg::ST_DELIVERED], status_seen[psdq_pkg::ST_EMPTY],
               status_seen[psdq_pkg::ST_FLUSHED]);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
